FILE: src/rpa_pkg.sv
package rpa_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 23;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_NIR_TARGET   = 3'd0;
  localparam cfg_idx_t CFG_RED_TARGET   = 3'd1;
  localparam cfg_idx_t CFG_TOLERANCE    = 3'd2;
  localparam cfg_idx_t CFG_SURFACE_MODE = 3'd3;
  localparam cfg_idx_t CFG_WATER_LIMIT  = 3'd4;
  localparam cfg_idx_t CFG_VEG_RATIO    = 3'd5;

  localparam logic [15:0] NIR_TARGET_RST  = 16'd13600;
  localparam logic [15:0] RED_TARGET_RST  = 16'd10560;
  localparam logic [15:0] TOLERANCE_RST   = 16'd1600;
  localparam logic        SURFACE_RST     = 1'b0;
  localparam logic [22:0] WATER_LIMIT_RST = 23'd9830;
  localparam logic [15:0] VEG_RATIO_RST   = 16'd512;

  // reflectance of exactly 1.0
  localparam logic signed [23:0] REFL_ONE = 24'sd65536;

  typedef enum logic {
    SURF_WATER      = 1'b0,
    SURF_VEGETATION = 1'b1
  } surface_e;

  typedef enum logic [1:0] {
    ANOM_NONE       = 2'd0,
    ANOM_RANGE      = 2'd1,
    ANOM_WATER      = 2'd2,
    ANOM_VEGETATION = 2'd3
  } anomaly_e;

  // one pixel as handed from the band tracker to the rule stage
  typedef struct packed {
    logic               found;
    logic               range_flag;
    logic [7:0]         nir_index;
    logic [7:0]         red_index;
    logic signed [23:0] nir_value;
    logic signed [23:0] red_value;
    logic [15:0]        nir_wavelength;
    logic [15:0]        red_wavelength;
  } pix_sum_t;

  typedef struct packed {
    logic [15:0] nir_target;
    logic [15:0] red_target;
    logic [15:0] tolerance;
    surface_e    surface_mode;
    logic [22:0] water_limit;
    logic [15:0] veg_ratio;
  } cfg_t;

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: src/rpa_band_if.sv
interface rpa_band_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] reflectance;
  logic [15:0]        band_wavelength;
  logic               last_band;

  modport source (output valid, output reflectance, output band_wavelength,
                  output last_band, input ready);
  modport sink (input valid, input reflectance, input band_wavelength,
                input last_band, output ready);
endinterface

FILE: src/rpa_audit_if.sv
interface rpa_audit_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic               anomaly_found;
  logic [1:0]         first_anomaly;
  logic               range_violation;
  logic               rule_violation;
  logic [7:0]         nir_band;
  logic [7:0]         red_band;
  logic signed [23:0] nir_reflectance;
  logic signed [23:0] red_reflectance;
  logic [15:0]        nir_wavelength;
  logic [15:0]        red_wavelength;

  modport source (output valid, output status, output anomaly_found, output first_anomaly,
                  output range_violation, output rule_violation, output nir_band,
                  output red_band, output nir_reflectance, output red_reflectance,
                  output nir_wavelength, output red_wavelength, input ready);
  modport sink (input valid, input status, input anomaly_found, input first_anomaly,
                input range_violation, input rule_violation, input nir_band,
                input red_band, input nir_reflectance, input red_reflectance,
                input nir_wavelength, input red_wavelength, output ready);
endinterface

FILE: src/rpa_front.sv
module rpa_front #(
  parameter int unsigned MAX_BANDS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rpa_band_if.sink          band_i,
  input  rpa_pkg::cfg_t     cfg_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output rpa_pkg::pix_sum_t push_data_o
);

  localparam logic [7:0] IdxLimit = (MAX_BANDS - 1 < 255) ? 8'(MAX_BANDS - 1) : 8'd255;

  logic [7:0]         idx_q, idx_d;
  logic               range_q, range_d;
  logic               nir_found_q, nir_found_d, red_found_q, red_found_d;
  logic [15:0]        nir_dist_q, nir_dist_d, red_dist_q, red_dist_d;
  logic [7:0]         nir_idx_q, nir_idx_d, red_idx_q, red_idx_d;
  logic signed [23:0] nir_val_q, nir_val_d, red_val_q, red_val_d;
  logic [15:0]        nir_wl_q, nir_wl_d, red_wl_q, red_wl_d;

  logic        accept;
  logic [15:0] nir_bound, red_bound, nir_dist, red_dist;
  logic        nir_hit, red_hit, out_of_range;

  assign band_i.ready = push_ready_i;
  assign accept       = band_i.valid & band_i.ready;

  always_comb begin
    // tolerance is taken afresh on the first band of a pixel
    nir_bound    = (idx_q == '0) ? cfg_i.tolerance : nir_dist_q;
    red_bound    = (idx_q == '0) ? cfg_i.tolerance : red_dist_q;
    nir_dist     = rpa_pkg::abs_diff(band_i.band_wavelength, cfg_i.nir_target);
    red_dist     = rpa_pkg::abs_diff(band_i.band_wavelength, cfg_i.red_target);
    nir_hit      = (band_i.band_wavelength != '0) && (nir_dist < nir_bound);
    red_hit      = (band_i.band_wavelength != '0) && (red_dist < red_bound);
    out_of_range = band_i.reflectance[23] || (band_i.reflectance > rpa_pkg::REFL_ONE);

    nir_dist_d  = nir_hit ? nir_dist : nir_bound;
    red_dist_d  = red_hit ? red_dist : red_bound;
    nir_found_d = nir_found_q | nir_hit;
    red_found_d = red_found_q | red_hit;
    nir_idx_d   = nir_hit ? idx_q : nir_idx_q;
    red_idx_d   = red_hit ? idx_q : red_idx_q;
    nir_val_d   = nir_hit ? band_i.reflectance : nir_val_q;
    red_val_d   = red_hit ? band_i.reflectance : red_val_q;
    nir_wl_d    = nir_hit ? band_i.band_wavelength : nir_wl_q;
    red_wl_d    = red_hit ? band_i.band_wavelength : red_wl_q;
    range_d     = range_q | out_of_range;
    idx_d       = (idx_q < IdxLimit) ? idx_q + 8'd1 : idx_q;

    push_data_o.found          = nir_found_d & red_found_d;
    push_data_o.range_flag     = range_d;
    push_data_o.nir_index      = nir_idx_d;
    push_data_o.red_index      = red_idx_d;
    push_data_o.nir_value      = nir_val_d;
    push_data_o.red_value      = red_val_d;
    push_data_o.nir_wavelength = nir_wl_d;
    push_data_o.red_wavelength = red_wl_d;
  end

  assign push_valid_o = accept & band_i.last_band;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      range_q     <= 1'b0;
      nir_found_q <= 1'b0;
      red_found_q <= 1'b0;
    end else if (accept) begin
      if (band_i.last_band) begin
        idx_q       <= '0;
        range_q     <= 1'b0;
        nir_found_q <= 1'b0;
        red_found_q <= 1'b0;
      end else begin
        idx_q       <= idx_d;
        range_q     <= range_d;
        nir_found_q <= nir_found_d;
        red_found_q <= red_found_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      nir_dist_q <= nir_dist_d;
      red_dist_q <= red_dist_d;
      nir_idx_q  <= nir_idx_d;
      red_idx_q  <= red_idx_d;
      nir_val_q  <= nir_val_d;
      red_val_q  <= red_val_d;
      nir_wl_q   <= nir_wl_d;
      red_wl_q   <= red_wl_d;
    end
  end

endmodule

FILE: src/rpa_queue.sv
module rpa_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  rpa_pkg::pix_sum_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output rpa_pkg::pix_sum_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  rpa_pkg::pix_sum_t mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/rpa_back.sv
module rpa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpa_pkg::cfg_t     cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  rpa_pkg::pix_sum_t pop_data_i,
  rpa_audit_if.source       audit_o
);

  logic               s1_v_q;
  rpa_pkg::pix_sum_t  s1_q;
  logic signed [40:0] prod_q, prod_d;
  logic               out_v_q;
  logic               s1_ld, s2_ld;

  logic signed [40:0] nir_scaled;
  logic               water_fail, veg_fail, rule;
  rpa_pkg::anomaly_e  rule_code;

  logic               status_q, has_anom_q, range_q, rule_q;
  rpa_pkg::anomaly_e  code_q;
  logic [7:0]         nir_band_q, red_band_q;
  logic signed [23:0] nir_refl_q, red_refl_q;
  logic [15:0]        nir_wl_q, red_wl_q;

  assign s2_ld       = s1_v_q & (~out_v_q | audit_o.ready);
  assign s1_ld       = pop_valid_i & (~s1_v_q | s2_ld);
  assign pop_ready_o = ~s1_v_q | s2_ld;

  // ratio * red for the vegetation test
  assign prod_d = $signed({1'b0, cfg_i.veg_ratio}) * pop_data_i.red_value;

  always_comb begin
    nir_scaled = $signed({{9{s1_q.nir_value[23]}}, s1_q.nir_value, 8'h00});
    water_fail = (s1_q.nir_value > s1_q.red_value) &&
                 ($signed({s1_q.nir_value[23], s1_q.nir_value}) >
                  $signed({2'b00, cfg_i.water_limit}));
    veg_fail   = (s1_q.red_value > 24'sd0) && (nir_scaled < prod_q);
    if (cfg_i.surface_mode == rpa_pkg::SURF_WATER) begin
      rule      = water_fail;
      rule_code = rpa_pkg::ANOM_WATER;
    end else begin
      rule      = veg_fail;
      rule_code = rpa_pkg::ANOM_VEGETATION;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_v_q <= 1'b1;
      end else if (s2_ld) begin
        s1_v_q <= 1'b0;
      end
      if (s2_ld) begin
        out_v_q <= 1'b1;
      end else if (audit_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ld) begin
      s1_q   <= pop_data_i;
      prod_q <= prod_d;
    end
    if (s2_ld) begin
      if (!s1_q.found) begin
        status_q   <= 1'b1;
        has_anom_q <= 1'b0;
        code_q     <= rpa_pkg::ANOM_NONE;
        range_q    <= 1'b0;
        rule_q     <= 1'b0;
        nir_band_q <= '0;
        red_band_q <= '0;
        nir_refl_q <= '0;
        red_refl_q <= '0;
        nir_wl_q   <= '0;
        red_wl_q   <= '0;
      end else begin
        status_q   <= 1'b0;
        has_anom_q <= s1_q.range_flag | rule;
        if (s1_q.range_flag) begin
          code_q <= rpa_pkg::ANOM_RANGE;
        end else if (rule) begin
          code_q <= rule_code;
        end else begin
          code_q <= rpa_pkg::ANOM_NONE;
        end
        range_q    <= s1_q.range_flag;
        rule_q     <= rule;
        nir_band_q <= s1_q.nir_index;
        red_band_q <= s1_q.red_index;
        nir_refl_q <= s1_q.nir_value;
        red_refl_q <= s1_q.red_value;
        nir_wl_q   <= s1_q.nir_wavelength;
        red_wl_q   <= s1_q.red_wavelength;
      end
    end
  end

  assign audit_o.valid           = out_v_q;
  assign audit_o.status          = status_q;
  assign audit_o.anomaly_found   = has_anom_q;
  assign audit_o.first_anomaly   = code_q;
  assign audit_o.range_violation = range_q;
  assign audit_o.rule_violation  = rule_q;
  assign audit_o.nir_band        = nir_band_q;
  assign audit_o.red_band        = red_band_q;
  assign audit_o.nir_reflectance = nir_refl_q;
  assign audit_o.red_reflectance = red_refl_q;
  assign audit_o.nir_wavelength  = nir_wl_q;
  assign audit_o.red_wavelength  = red_wl_q;

endmodule

FILE: src/reflectance_physics_audit_unit.sv
// spectral audit of one pixel at a time
// band_i carries a pixel's bands, one per cycle while band_i.ready is high,
// last_band on the last. audit_o gives one item per pixel, after its last band.
// cfg_we_i/cfg_idx_i/cfg_data_i write the six setup registers; write them only
// while no pixel is in flight.
// throughput: one band per cycle while band_i.ready is high, with back-to-back
// pixels. the audit item of a pixel passes from the pixel queue to the
// multiplier register and then to the output register.
// a two-entry pixel queue sits between the band tracker and the rule stage;
// if the receiver stalls, the queue and the two rule stages fill, and only then
// band_i.ready drops, for all bands, until the receiver takes an audit item.
// reset clears the band counter, the per-pixel flags and all valid flags, and
// loads the setup registers with their default targets and limits.
// the band index saturates at the smaller of MAX_BANDS-1 and 255.
module reflectance_physics_audit_unit #(
  parameter int unsigned MAX_BANDS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rpa_band_if.sink                      band_i,
  rpa_audit_if.source                   audit_o,
  input  logic                          cfg_we_i,
  input  logic [rpa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rpa_pkg::CfgDataW-1:0]  cfg_data_i
);

  rpa_pkg::cfg_t     cfg_q;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  rpa_pkg::pix_sum_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nir_target   <= rpa_pkg::NIR_TARGET_RST;
      cfg_q.red_target   <= rpa_pkg::RED_TARGET_RST;
      cfg_q.tolerance    <= rpa_pkg::TOLERANCE_RST;
      cfg_q.surface_mode <= rpa_pkg::surface_e'(rpa_pkg::SURFACE_RST);
      cfg_q.water_limit  <= rpa_pkg::WATER_LIMIT_RST;
      cfg_q.veg_ratio    <= rpa_pkg::VEG_RATIO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpa_pkg::CFG_NIR_TARGET:   cfg_q.nir_target   <= cfg_data_i[15:0];
        rpa_pkg::CFG_RED_TARGET:   cfg_q.red_target   <= cfg_data_i[15:0];
        rpa_pkg::CFG_TOLERANCE:    cfg_q.tolerance    <= cfg_data_i[15:0];
        rpa_pkg::CFG_SURFACE_MODE: cfg_q.surface_mode <= rpa_pkg::surface_e'(cfg_data_i[0]);
        rpa_pkg::CFG_WATER_LIMIT:  cfg_q.water_limit  <= cfg_data_i[22:0];
        rpa_pkg::CFG_VEG_RATIO:    cfg_q.veg_ratio    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  rpa_front #(
    .MAX_BANDS (MAX_BANDS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .band_i       (band_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rpa_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .audit_o     (audit_o)
  );

endmodule

FILE: src/rpa_checker.sv
module rpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        status_i,
  input logic        anomaly_found_i,
  input logic [1:0]  first_anomaly_i,
  input logic        range_violation_i,
  input logic        rule_violation_i,
  input logic [7:0]  nir_band_i,
  input logic [15:0] nir_wavelength_i
);

  // a stalled audit item keeps its verdict
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(status_i) && $stable(first_anomaly_i)
      && $stable(nir_band_i))
    else $error("audit item changed while stalled");

  // a pixel without both bands reports nothing else
  a_missing_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i |-> !anomaly_found_i && !range_violation_i && !rule_violation_i
      && (nir_band_i == 8'd0) && (nir_wavelength_i == 16'd0))
    else $error("missing-band audit carries data");

  a_anomaly_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> anomaly_found_i == (range_violation_i || rule_violation_i))
    else $error("anomaly flag disagrees with the violation flags");

  // range anomaly takes precedence in the code
  a_code_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && range_violation_i |-> first_anomaly_i == 2'(rpa_pkg::ANOM_RANGE))
    else $error("range anomaly not reported first");

endmodule

bind reflectance_physics_audit_unit rpa_checker u_rpa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .valid_i           (audit_o.valid),
  .ready_i           (audit_o.ready),
  .status_i          (audit_o.status),
  .anomaly_found_i   (audit_o.anomaly_found),
  .first_anomaly_i   (audit_o.first_anomaly),
  .range_violation_i (audit_o.range_violation),
  .rule_violation_i  (audit_o.rule_violation),
  .nir_band_i        (audit_o.nir_band),
  .nir_wavelength_i  (audit_o.nir_wavelength)
);
